FILE: rtl/assert_macros.svh
// Assertion macros shared by the button hold tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: rtl/btnh_pkg.sv
// Shared types, constants and helpers for the button hold tracker.
package btnh_pkg;

    localparam int CNT_W            = 16;
    localparam int MASK_BITS        = 8;
    localparam int IN_IDX_W         = 3;
    localparam int CFG_IDX_W        = 1;
    localparam int DEF_BUTTON_COUNT = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX     = 16'hFFFD;
    localparam logic [CNT_W-1:0] RELEASED_MARK = 16'hFFFF;
    localparam logic [CNT_W-1:0] CFG_RESET_VAL = 16'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // counter store update request
    typedef struct packed {
        logic upd;
        logic down;
    } t_cnt_req;

    // remainder unit request and response
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_rem_rsp;

    function automatic int idx_width(input int n);
        idx_width = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: rtl/btnh_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`include "assert_macros.svh"

module btnh_rem import btnh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    localparam int STEP_W = $clog2(CNT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_part;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  n_part;

    assign shifted = {r_part, r_num[CNT_W-1]};
    assign trial   = shifted - {1'b0, r_den};
    // keep the difference when it did not borrow
    assign n_part  = trial[CNT_W] ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_part <= '0;
            end else if (r_busy) begin
                r_part <= n_part;
                r_num  <= {r_num[CNT_W-2:0], 1'b0};
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_part;

    `CHK_IMPL(a_rem_no_restart, i_clk, i_rst_n, i_req.start, !r_busy)
    `CHK_IMPL(a_rem_bounded, i_clk, i_rst_n, r_done, r_part < r_den)

endmodule

FILE: rtl/btnh_cnt.sv
// Per-button hold counter store with press/hold/release update.
`include "assert_macros.svh"

module btnh_cnt import btnh_pkg::*; #(
    parameter int BUTTON_COUNT = DEF_BUTTON_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [idx_width(BUTTON_COUNT)-1:0] i_addr,
    input  t_cnt_req                           i_req,
    output logic [CNT_W-1:0]                   o_count
);

    logic [CNT_W-1:0] r_count [BUTTON_COUNT];
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] n_count;

    function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] c,
                                                    input logic down);
        logic [CNT_W-1:0] res;
        if (down) begin
            if (c < COUNT_MAX)          res = c + CNT_W'(1);
            else if (c == RELEASED_MARK) res = CNT_W'(1);
            else                         res = c;
        end else begin
            if (c == '0 || c == RELEASED_MARK) res = '0;
            else                               res = RELEASED_MARK;
        end
        return res;
    endfunction

    assign cur     = r_count[i_addr];
    assign n_count = next_count(cur, i_req.down);
    assign o_count = i_req.upd ? n_count : cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUTTON_COUNT; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_req.upd) begin
            r_count[i_addr] <= n_count;
        end
    end

    `CHK_NEXT(a_cnt_written, i_clk, i_rst_n, i_req.upd, r_count[$past(i_addr)] == $past(o_count))

endmodule

FILE: rtl/button_hold_tracker.sv
// Button hold tracker: one frame tick or query per item, buttons walked in turn.
// Per item: S_STEP for each button in turn, with an S_DIV remainder step after each live
//   button when repeat_period >= 2, then S_DONE to load the result register.
// Items are taken one at a time; o_ready is high only in S_IDLE, between items, and
//   S_DONE waits while an earlier result has not been taken.
// Reset (synchronous, active low): counters idle, both registers 1, o_valid low.
`include "assert_macros.svh"

module button_hold_tracker import btnh_pkg::*; #(
    parameter int BUTTON_COUNT = DEF_BUTTON_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic [MASK_BITS-1:0] i_button_bits,
    input  logic [IN_IDX_W-1:0]  i_button_index,
    // result items
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MASK_BITS-1:0] o_pressed_mask,
    output logic [MASK_BITS-1:0] o_released_mask,
    output logic [MASK_BITS-1:0] o_held_mask,
    output logic [MASK_BITS-1:0] o_repeat_mask,
    output logic [CNT_W-1:0]     o_time_held
);

    localparam int IDX_W = idx_width(BUTTON_COUNT);
    // compare width wide enough for the button index and for the value 8
    localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DIV,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_cmd;
    logic [MASK_BITS-1:0] r_bits;
    logic [IN_IDX_W-1:0]  r_sel;
    logic [CNT_W-1:0]     r_hold_frames;
    logic [CNT_W-1:0]     r_repeat_period;

    // masks and hold time under construction
    logic [MASK_BITS-1:0] r_pm, r_rm, r_hm, r_pr;
    logic [CNT_W-1:0]     r_th;

    // result register
    logic                 r_out_valid;
    logic [MASK_BITS-1:0] r_out_pm, r_out_rm, r_out_hm, r_out_pr;
    logic [CNT_W-1:0]     r_out_th;

    t_cnt_req             cnt_req;
    logic [CNT_W-1:0]     cnt_val;
    t_rem_req             rem_req;
    t_rem_rsp             rem_rsp;

    logic [CMP_W-1:0]     idx_ext;
    logic                 in_mask;
    logic [MASK_BITS-1:0] bit_sel;
    logic                 is_live;
    logic                 need_div;
    logic                 hit_held;
    logic                 hit_sel;
    logic                 last_btn;
    logic [CNT_W:0]       held_target;

    assign idx_ext  = CMP_W'(r_idx);
    // only the first eight buttons have a pressed bit and a mask bit
    assign in_mask  = idx_ext < CMP_W'(MASK_BITS);
    assign bit_sel  = in_mask ? (MASK_BITS'(1) << idx_ext[2:0]) : '0;
    assign last_btn = (r_idx == IDX_W'(BUTTON_COUNT - 1));
    assign hit_sel  = (idx_ext == CMP_W'(r_sel));

    assign cnt_req.upd  = (r_state == S_STEP) && (r_cmd == CMD_TICK);
    assign cnt_req.down = in_mask && r_bits[idx_ext[2:0]];

    btnh_cnt #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (r_idx),
        .i_req   (cnt_req),
        .o_count (cnt_val)
    );

    // held target formed in 17 bits so 0xFFFF + 1 never wraps to a match
    assign held_target = {1'b0, r_hold_frames} + (CNT_W + 1)'(1);
    assign hit_held    = (cnt_val != RELEASED_MARK) && ({1'b0, cnt_val} == held_target);
    assign is_live     = (cnt_val != '0) && (cnt_val != RELEASED_MARK);
    assign need_div    = is_live && (r_repeat_period > CNT_W'(1));

    assign rem_req.start    = (r_state == S_STEP) && need_div;
    assign rem_req.dividend = cnt_val;
    assign rem_req.divisor  = r_repeat_period;

    btnh_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_hold_frames   <= CFG_RESET_VAL;
            r_repeat_period <= CFG_RESET_VAL;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HOLD_FRAMES:   r_hold_frames   <= i_cfg_data;
                    CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                    default: ;
                endcase
            end

            // S_DONE reloads the result register itself
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_command;
                        r_bits  <= i_button_bits;
                        r_sel   <= i_button_index;
                        r_idx   <= '0;
                        r_pm    <= '0;
                        r_rm    <= '0;
                        r_hm    <= '0;
                        r_pr    <= '0;
                        r_th    <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    // cnt_val is the counter after this item's update
                    if (cnt_val == CNT_W'(1))      r_pm <= r_pm | bit_sel;
                    if (cnt_val == RELEASED_MARK)  r_rm <= r_rm | bit_sel;
                    if (hit_held)                  r_hm <= r_hm | bit_sel;
                    if (is_live && !need_div)      r_pr <= r_pr | bit_sel;
                    if (hit_sel) begin
                        r_th <= (cnt_val == RELEASED_MARK) ? '0 : cnt_val;
                    end
                    if (need_div) begin
                        r_state <= S_DIV;
                    end else if (last_btn) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DIV: begin
                    if (rem_rsp.done) begin
                        if (rem_rsp.rem == CNT_W'(1)) r_pr <= r_pr | bit_sel;
                        if (last_btn) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_STEP;
                        end
                    end
                end
                S_DONE: begin
                    // result register free or being emptied this cycle
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pm    <= r_pm;
                        r_out_rm    <= r_rm;
                        r_out_hm    <= r_hm;
                        r_out_pr    <= r_pr;
                        r_out_th    <= r_th;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_pressed_mask  = r_out_pm;
    assign o_released_mask = r_out_rm;
    assign o_held_mask     = r_out_hm;
    assign o_repeat_mask   = r_out_pr;
    assign o_time_held     = r_out_th;

    `CHK_IMPL(a_th_not_marker, i_clk, i_rst_n, r_out_valid, r_out_th != RELEASED_MARK)
    `CHK_IMPL(a_press_rel_apart, i_clk, i_rst_n, r_out_valid, (r_out_pm & r_out_rm) == '0)

endmodule
